/* sv/cwa_pkg.sv */
// Shared types and constants of the chromatogram window aggregator.
// Used by the channel interfaces, the accumulator and the top level; no dependencies.
package cwa_pkg;

	localparam int TIME_W  = 32;
	localparam int MASS_W  = 32;
	localparam int LEVEL_W = 32;
	localparam int AGG_W   = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_MASS  = 3'd0,
		REG_HIGH_MASS = 3'd1,
		REG_LOW_TIME  = 3'd2,
		REG_HIGH_TIME = 3'd3,
		REG_AGG_MODE  = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		MODE_SUM = 1'b0,
		MODE_MAX = 1'b1
	} agg_mode_t;

	typedef struct packed {
		logic [MASS_W-1:0] low_mass;
		logic [MASS_W-1:0] high_mass;
		logic [TIME_W-1:0] low_time;
		logic [TIME_W-1:0] high_time;
		agg_mode_t         mode;
	} cwa_cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]  scan_time;
		logic [MASS_W-1:0]  mass;
		logic [LEVEL_W-1:0] level;
		logic               has_point;
		logic               scan_end;
	} cwa_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] out_time;
		logic [AGG_W-1:0]  aggregate;
		logic              saturated;
	} cwa_result_t;

endpackage

/* sv/cwa_item_if.sv */
// Input channel of the aggregator: one spectrum point per word.
// Depends on cwa_pkg for the field widths.
interface cwa_item_if;
	logic                         valid;
	logic                         ready;
	logic [cwa_pkg::TIME_W-1:0]   scan_time;
	logic [cwa_pkg::MASS_W-1:0]   mass;
	logic [cwa_pkg::LEVEL_W-1:0]  level;
	logic                         has_point;
	logic                         scan_end;

	modport source (output valid, scan_time, mass, level, has_point, scan_end, input ready);
	modport sink   (input valid, scan_time, mass, level, has_point, scan_end, output ready);
endinterface

/* sv/cwa_result_if.sv */
// Output channel of the aggregator: one finished scan per word.
// Depends on cwa_pkg for the field widths.
interface cwa_result_if;
	logic                        valid;
	logic                        ready;
	logic [cwa_pkg::TIME_W-1:0]  out_time;
	logic [cwa_pkg::AGG_W-1:0]   aggregate;
	logic                        saturated;

	modport source (output valid, out_time, aggregate, saturated, input ready);
	modport sink   (input valid, out_time, aggregate, saturated, output ready);
endinterface

/* sv/cwa_cfg_if.sv */
// Register write channel of the aggregator: register index and write data.
// Depends on cwa_pkg for the field widths.
interface cwa_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [cwa_pkg::CFG_IDX_W-1:0]    index;
	logic [cwa_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* sv/cwa_accum.sv */
// Per-scan accumulator: window compare, saturating sum or maximum, scan state.
// Depends on cwa_pkg for the item, configuration and result types.
module cwa_accum #(
	parameter int LEVEL_BITS = 32,
	parameter int SUM_BITS   = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cwa_pkg::cwa_cfg_t    cfg,
	input  cwa_pkg::cwa_item_t   item,
	input  logic                 step,
	output logic                 emit,
	output cwa_pkg::cwa_result_t result
);

	localparam int LV_W  = (LEVEL_BITS < cwa_pkg::LEVEL_W) ? LEVEL_BITS : cwa_pkg::LEVEL_W;
	localparam int ADD_W = ((SUM_BITS > LV_W) ? SUM_BITS : LV_W) + 1;
	localparam int OUT_W = (SUM_BITS > cwa_pkg::AGG_W) ? SUM_BITS : cwa_pkg::AGG_W;
	localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

	logic [SUM_BITS-1:0] running_q, run_next;
	logic                clip_q, clip_next;
	logic                has_data_q, has_next;

	logic [ADD_W-1:0]    lvl_ext, sum_full;
	logic                sum_ovf, lvl_ovf, in_mass, in_time;
	logic [SUM_BITS-1:0] lvl_clip;
	logic [OUT_W-1:0]    agg_wide;

	assign lvl_ext  = ADD_W'(item.level[LV_W-1:0]);
	assign sum_full = ADD_W'(running_q) + lvl_ext;
	// Anything above the low SUM_BITS bits means the value left the sum range.
	assign sum_ovf  = |sum_full[ADD_W-1:SUM_BITS];
	assign lvl_ovf  = |lvl_ext[ADD_W-1:SUM_BITS];
	assign lvl_clip = lvl_ovf ? SUM_MAX : lvl_ext[SUM_BITS-1:0];

	assign in_mass = (item.mass >= cfg.low_mass) && (item.mass <= cfg.high_mass);
	assign in_time = (item.scan_time >= cfg.low_time) && (item.scan_time <= cfg.high_time);

	always_comb begin
		run_next  = running_q;
		clip_next = clip_q;
		has_next  = has_data_q;
		if (item.has_point) begin
			has_next = 1'b1;
			if (in_mass) begin
				unique case (cfg.mode)
					cwa_pkg::MODE_SUM: begin
						if (sum_ovf) begin
							run_next  = SUM_MAX;
							clip_next = 1'b1;
						end else begin
							run_next = sum_full[SUM_BITS-1:0];
						end
					end
					cwa_pkg::MODE_MAX: begin
						if (lvl_ovf) begin
							clip_next = 1'b1;
						end
						if (lvl_clip > running_q) begin
							run_next = lvl_clip;
						end
					end
					default: begin
						run_next = running_q;
					end
				endcase
			end
		end
	end

	assign emit     = item.scan_end && has_next && in_time;
	assign agg_wide = OUT_W'(run_next);
	assign result.out_time  = item.scan_time;
	assign result.aggregate = agg_wide[cwa_pkg::AGG_W-1:0];
	assign result.saturated = clip_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= '0;
			clip_q     <= 1'b0;
			has_data_q <= 1'b0;
		end else if (step) begin
			if (item.scan_end) begin
				running_q  <= '0;
				clip_q     <= 1'b0;
				has_data_q <= 1'b0;
			end else begin
				running_q  <= run_next;
				clip_q     <= clip_next;
				has_data_q <= has_next;
			end
		end
	end

	// Every scan starts over once its last word has been taken.
	a_scan_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.scan_end |=> running_q == '0 && !clip_q && !has_data_q)
		else $error("scan state not cleared after end of scan");

	a_clip_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		clip_q |-> has_data_q)
		else $error("saturation flag set in a scan without points");

	a_value_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		running_q != '0 |-> has_data_q)
		else $error("nonzero aggregate in a scan without points");

endmodule

/* sv/chromatogram_window_aggregator_top.sv */
// Top level of the chromatogram window aggregator: register file, input register
// and output register around cwa_accum. Depends on cwa_pkg and the three channel interfaces.
//
// Usage: spectrum points enter on the points channel in scan order, one word per
// point, with scan_end set on the last word of a scan and has_point cleared on
// the single word of an empty scan. Registers are written on the cfg channel
// (index 0..4: low_mass, high_mass, low_time, high_time, aggregate_mode), which
// is always ready; write them only while no scan is in flight.
// Throughput: one point per cycle while no result word waits for the output register.
// A word taken sits in the input register and is folded into the scan state when it
// leaves that register; at that same edge a finished scan is loaded into the output
// register, so a result passes the input register and then the output register.
// When the receiver stalls, the output register holds its word; the input
// register keeps taking points that finish no scan, and only a word that ends a
// scan with a result waits for the output register to free. points.ready is low
// for as long as that word waits.
// Reset clears the registers to the full windows in sum mode, empties both
// stages and clears the scan state; it takes effect at once.
module chromatogram_window_aggregator_top #(
	parameter int LEVEL_BITS = 32,
	parameter int SUM_BITS   = 48
) (
	input logic          clk,
	input logic          arst_n,
	cwa_item_if.sink     points,
	cwa_result_if.source results,
	cwa_cfg_if.sink      cfg
);

	cwa_pkg::cwa_cfg_t    cfg_q;
	cwa_pkg::cwa_item_t   item_s1;
	logic                 s1_valid_q;
	cwa_pkg::cwa_result_t res_q;
	logic                 out_valid_q;

	logic                 emit;
	cwa_pkg::cwa_result_t res_next;
	logic                 s1_adv;
	logic                 in_take;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_mass  <= '0;
			cfg_q.high_mass <= '1;
			cfg_q.low_time  <= '0;
			cfg_q.high_time <= '1;
			cfg_q.mode      <= cwa_pkg::MODE_SUM;
		end else if (cfg.valid) begin
			unique case (cwa_pkg::cfg_reg_t'(cfg.index))
				cwa_pkg::REG_LOW_MASS:  cfg_q.low_mass  <= cfg.data[cwa_pkg::MASS_W-1:0];
				cwa_pkg::REG_HIGH_MASS: cfg_q.high_mass <= cfg.data[cwa_pkg::MASS_W-1:0];
				cwa_pkg::REG_LOW_TIME:  cfg_q.low_time  <= cfg.data[cwa_pkg::TIME_W-1:0];
				cwa_pkg::REG_HIGH_TIME: cfg_q.high_time <= cfg.data[cwa_pkg::TIME_W-1:0];
				cwa_pkg::REG_AGG_MODE:  cfg_q.mode      <= cwa_pkg::agg_mode_t'(cfg.data[0]);
				default: begin
				end
			endcase
		end
	end

	// A word that produces no result never waits for the output register.
	assign s1_adv      = s1_valid_q && (!emit || !out_valid_q || results.ready);
	assign points.ready = !s1_valid_q || s1_adv;
	assign in_take     = points.valid && points.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_take) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.scan_time <= points.scan_time;
			item_s1.mass      <= points.mass;
			item_s1.level     <= points.level;
			item_s1.has_point <= points.has_point;
			item_s1.scan_end  <= points.scan_end;
		end
	end

	cwa_accum #(
		.LEVEL_BITS (LEVEL_BITS),
		.SUM_BITS   (SUM_BITS)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item_s1),
		.step   (s1_adv),
		.emit   (emit),
		.result (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			res_q <= res_next;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.out_time  = res_q.out_time;
	assign results.aggregate = res_q.aggregate;
	assign results.saturated = res_q.saturated;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(item_s1))
		else $error("input register changed while its word was stalled");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_adv && emit))
		else $error("result word appeared without a finished scan");

	a_out_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.out_time >= cfg_q.low_time && res_q.out_time <= cfg_q.high_time)
		else $error("result word outside the time window");

endmodule

/* test/tb_top.sv */
// Testbench of the chromatogram window aggregator: drives spectrum points and register writes,
// predicts every finished scan and checks each result word against it.
// Depends on cwa_pkg, the three channel interfaces and chromatogram_window_aggregator_top.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEVEL_BITS = 32;
	localparam int SUM_BITS   = 48;
	localparam bit [63:0] LEVEL_MASK = ((64'd1 << (LEVEL_BITS - 1)) << 1) - 64'd1;
	localparam bit [63:0] SUM_LIMIT  = ((64'd1 << (SUM_BITS - 1)) << 1) - 64'd1;
	localparam bit [31:0] ALL_ONES   = 32'hFFFF_FFFF;

	// Predicts the scan results from the accepted points and holds them until they arrive.
	class scan_scoreboard;
		bit [31:0]            low_mass, high_mass, low_time, high_time;
		cwa_pkg::agg_mode_t   mode;
		bit [63:0]            running;
		bit                   clipped;
		bit                   seen_point;
		cwa_pkg::cwa_result_t pending_scans[$];
		int                   errors;

		function new();
			low_mass   = 32'd0;
			high_mass  = ALL_ONES;
			low_time   = 32'd0;
			high_time  = ALL_ONES;
			mode       = cwa_pkg::MODE_SUM;
			running    = 64'd0;
			clipped    = 1'b0;
			seen_point = 1'b0;
			errors     = 0;
		endfunction

		function void set_register(cwa_pkg::cfg_reg_t idx, bit [31:0] value);
			case (idx)
				cwa_pkg::REG_LOW_MASS:  low_mass = value;
				cwa_pkg::REG_HIGH_MASS: high_mass = value;
				cwa_pkg::REG_LOW_TIME:  low_time = value;
				cwa_pkg::REG_HIGH_TIME: high_time = value;
				cwa_pkg::REG_AGG_MODE:  mode = cwa_pkg::agg_mode_t'(value[0]);
				default: ;
			endcase
		endfunction

		function int outstanding();
			return pending_scans.size();
		endfunction

		function void note_point(cwa_pkg::cwa_item_t it);
			bit [63:0]            v;
			cwa_pkg::cwa_result_t r;
			v = {32'd0, it.level} & LEVEL_MASK;
			if (it.has_point) begin
				seen_point = 1'b1;
				if (it.mass >= low_mass && it.mass <= high_mass) begin
					if (mode == cwa_pkg::MODE_SUM) begin
						if (v > SUM_LIMIT - running) begin
							running = SUM_LIMIT;
							clipped = 1'b1;
						end else begin
							running = running + v;
						end
					end else begin
						if (v > SUM_LIMIT) begin
							v = SUM_LIMIT;
							clipped = 1'b1;
						end
						if (v > running)
							running = v;
					end
				end
			end
			if (it.scan_end) begin
				if (seen_point && it.scan_time >= low_time && it.scan_time <= high_time) begin
					r.out_time  = it.scan_time;
					r.aggregate = running[cwa_pkg::AGG_W-1:0];
					r.saturated = clipped;
					pending_scans = {pending_scans, r};
				end
				running    = 64'd0;
				clipped    = 1'b0;
				seen_point = 1'b0;
			end
		endfunction

		function void check_scan(cwa_pkg::cwa_result_t got);
			cwa_pkg::cwa_result_t want;
			if (pending_scans.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("tb: unexpected scan word time=%h aggregate=%h saturated=%b",
						got.out_time, got.aggregate, got.saturated);
				return;
			end
			want = pending_scans.pop_front();
			if (got.out_time !== want.out_time || got.aggregate !== want.aggregate ||
					got.saturated !== want.saturated) begin
				errors++;
				if (errors <= 10)
					$display({"tb: scan mismatch expected time=%h aggregate=%h saturated=%b,",
						" got time=%h aggregate=%h saturated=%b"},
						want.out_time, want.aggregate, want.saturated,
						got.out_time, got.aggregate, got.saturated);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cwa_item_if   points_ch();
	cwa_result_if results_ch();
	cwa_cfg_if    cfg_ch();

	chromatogram_window_aggregator_top #(
		.LEVEL_BITS(LEVEL_BITS),
		.SUM_BITS(SUM_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.points(points_ch),
		.results(results_ch),
		.cfg(cfg_ch)
	);

	scan_scoreboard sb = new();

	bit        idling = 1'b0;
	int        ready_hold = 0;
	int        items_sent = 0;
	bit [31:0] cur_low_mass = 32'd0, cur_high_mass = ALL_ONES;
	bit [31:0] cur_low_time = 32'd0, cur_high_time = ALL_ONES;

	always #10 clk = ~clk;

	initial begin
		points_ch.valid     = 1'b0;
		points_ch.scan_time = '0;
		points_ch.mass      = '0;
		points_ch.level     = '0;
		points_ch.has_point = 1'b0;
		points_ch.scan_end  = 1'b0;
		results_ch.ready    = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
	end

	// Accepted words on both channels go to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && points_ch.valid && points_ch.ready)
			sb.note_point(cwa_pkg::cwa_item_t'{scan_time: points_ch.scan_time,
				mass: points_ch.mass, level: points_ch.level,
				has_point: points_ch.has_point, scan_end: points_ch.scan_end});
		if (arst_n && results_ch.valid && results_ch.ready)
			sb.check_scan(cwa_pkg::cwa_result_t'{out_time: results_ch.out_time,
				aggregate: results_ch.aggregate, saturated: results_ch.saturated});
	end

	// Receiver stalls come in random bursts while idling is on.
	always @(posedge clk) begin
		if (!idling) begin
			results_ch.ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			results_ch.ready <= 1'b0;
			ready_hold <= $urandom_range(0, 7);
		end else begin
			results_ch.ready <= 1'b1;
			ready_hold <= $urandom_range(0, 15);
		end
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic send_point(input bit [31:0] t, input bit [31:0] m, input bit [31:0] lvl,
			input bit hp, input bit se);
		int gap;
		gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		if (gap > 0) begin
			points_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		points_ch.valid     <= 1'b1;
		points_ch.scan_time <= t;
		points_ch.mass      <= m;
		points_ch.level     <= lvl;
		points_ch.has_point <= hp;
		points_ch.scan_end  <= se;
		do @(posedge clk); while (!points_ch.ready);
		items_sent++;
	endtask

	task automatic write_reg(input cwa_pkg::cfg_reg_t idx, input bit [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_register(idx, value);
	endtask

	task automatic apply_config(input bit [31:0] lm, input bit [31:0] hm, input bit [31:0] lt,
			input bit [31:0] ht, input cwa_pkg::agg_mode_t md);
		bit [31:0] junk;
		junk = $urandom;
		write_reg(cwa_pkg::REG_LOW_MASS, lm);
		write_reg(cwa_pkg::REG_HIGH_MASS, hm);
		write_reg(cwa_pkg::REG_LOW_TIME, lt);
		write_reg(cwa_pkg::REG_HIGH_TIME, ht);
		// Only bit 0 of the mode word matters; the rest is filled at random.
		write_reg(cwa_pkg::REG_AGG_MODE, {junk[31:1], md});
		cfg_ch.valid <= 1'b0;
		cur_low_mass  = lm;
		cur_high_mass = hm;
		cur_low_time  = lt;
		cur_high_time = ht;
	endtask

	// Waits until every predicted scan has come out and the pipeline has emptied.
	task automatic drain(input int settle);
		points_ch.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic bit [31:0] near_bound(input bit [31:0] lo, input bit [31:0] hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			2: return lo - 32'd1;
			3: return hi + 32'd1;
			4: return lo + $urandom_range(0, 15);
			5: return hi - $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic bit [31:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return ALL_ONES;
			2: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	task automatic pick_window(output bit [31:0] lo, output bit [31:0] hi);
		bit [31:0] a, b;
		a = $urandom;
		b = $urandom;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
	endtask

	// One scan with random content; now and then an empty scan, a point-less word
	// inside the scan, a trailing point-less end word or a stray end time.
	task automatic random_scan();
		bit [31:0] t, t_end;
		int        n;
		bit        tail;
		t = near_bound(cur_low_time, cur_high_time);
		if ($urandom_range(0, 9) == 0) begin
			send_point(t, $urandom, $urandom, 1'b0, 1'b1);
			return;
		end
		n = $urandom_range(1, 8);
		tail = ($urandom_range(0, 3) == 0);
		t_end = ($urandom_range(0, 11) == 0) ? near_bound(cur_low_time, cur_high_time) : t;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_point(t, $urandom, $urandom, 1'b0, 1'b0);
			send_point((!tail && i == n - 1) ? t_end : t, near_bound(cur_low_mass, cur_high_mass),
				pick_level(), 1'b1, !tail && i == n - 1);
		end
		if (tail)
			send_point(t_end, $urandom, $urandom, 1'b0, 1'b1);
	endtask

	// Idling is switched at random between scans only when vary_idle is set.
	task automatic random_phase(input int count, input bit vary_idle);
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			if (vary_idle && $urandom_range(0, 7) == 0)
				idling = ($urandom_range(0, 3) != 0);
			random_scan();
		end
		drain(4);
	endtask

	initial begin
		bit [31:0] lm, hm, lt, ht;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset windows in sum mode.
		send_point(32'd0, 32'd0, 32'd0, 1'b0, 1'b1);
		send_point(32'd0, 32'd0, ALL_ONES, 1'b1, 1'b1);
		send_point(32'h1234_0000, ALL_ONES, 32'd0, 1'b1, 1'b0);
		send_point(32'h1234_0000, 32'h55AA_0000, 32'd1, 1'b1, 1'b0);
		send_point(32'h1234_0000, 32'd0, ALL_ONES, 1'b0, 1'b1);
		send_point(ALL_ONES, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
		drain(4);

		// Narrow windows in max mode: every bound, both sides of it.
		apply_config(32'h0010_0000, 32'h0020_0000, 32'h0005_0000, 32'h0006_0000,
			cwa_pkg::MODE_MAX);
		send_point(32'h0005_0000, 32'h0010_0000, 32'd5, 1'b1, 1'b0);
		send_point(32'h0005_0000, 32'h0020_0000, 32'd9, 1'b1, 1'b0);
		send_point(32'h0005_0000, 32'h000F_FFFF, 32'd100, 1'b1, 1'b0);
		send_point(32'h0005_0000, 32'h0020_0001, 32'd200, 1'b1, 1'b1);
		send_point(32'h0006_0000, 32'h0015_0000, 32'd7, 1'b1, 1'b1);
		send_point(32'h0004_FFFF, 32'h0015_0000, 32'd7, 1'b1, 1'b1);
		send_point(32'h0006_0001, 32'h0015_0000, 32'd7, 1'b1, 1'b1);
		send_point(32'h0005_8000, 32'd0, 32'd50, 1'b1, 1'b0);
		send_point(32'h0005_8000, ALL_ONES, 32'd60, 1'b1, 1'b1);
		send_point(32'h0005_8000, 32'h0018_0000, 32'd3, 1'b1, 1'b0);
		send_point(32'h0005_8000, 32'h0018_0000, ALL_ONES, 1'b0, 1'b0);
		send_point(32'h0005_8000, 32'h0019_0000, 32'd4, 1'b1, 1'b1);
		drain(4);

		// Inverted windows: nothing qualifies.
		apply_config(ALL_ONES, 32'd0, ALL_ONES, 32'd0, cwa_pkg::MODE_SUM);
		send_point(32'h0005_0000, 32'h0010_0000, 32'd5, 1'b1, 1'b1);
		drain(4);

		// Random part over several register settings, extremes first.
		idling = 1'b1;
		apply_config(32'd0, ALL_ONES, 32'd0, ALL_ONES, cwa_pkg::MODE_MAX);
		random_phase(160, 1'b1);
		lm = $urandom;
		lt = $urandom;
		apply_config(lm, lm, lt, lt, cwa_pkg::MODE_SUM);
		random_phase(160, 1'b1);
		pick_window(lm, hm);
		pick_window(lt, ht);
		apply_config(hm, lm, ht, lt, cwa_pkg::agg_mode_t'($urandom_range(0, 1)));
		random_phase(160, 1'b1);
		for (int p = 0; p < 3; p++) begin
			pick_window(lm, hm);
			pick_window(lt, ht);
			apply_config(lm, hm, lt, ht, cwa_pkg::agg_mode_t'($urandom_range(0, 1)));
			random_phase(160, 1'b1);
		end

		// Last part without idling on either side.
		idling = 1'b0;
		apply_config(32'd0, ALL_ONES, 32'd0, ALL_ONES, cwa_pkg::MODE_SUM);
		random_phase(100, 1'b0);
		pick_window(lm, hm);
		pick_window(lt, ht);
		apply_config(lm, hm, lt, ht, cwa_pkg::agg_mode_t'($urandom_range(0, 1)));
		random_phase(100, 1'b0);

		drain(8);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/cwa_pkg.sv
sv/cwa_item_if.sv
sv/cwa_result_if.sv
sv/cwa_cfg_if.sv
sv/cwa_accum.sv
sv/chromatogram_window_aggregator_top.sv
test/tb_top.sv
